// ----- rtl/core/lpbt_pkg.sv -----
`default_nettype none
package lpbt_pkg;

    localparam int ADDR_BYTES = 6;
    localparam int PEER_W     = 48;
    localparam int ADDR_W     = ADDR_BYTES * 8;
    localparam int KEEP_W     = (ADDR_W < PEER_W) ? ADDR_W : PEER_W;
    localparam logic [PEER_W-1:0] ADDR_MASK = {PEER_W{1'b1}} >> (PEER_W - KEEP_W);

    localparam int ROLE_W  = 8;
    localparam int TIME_W  = 64;
    localparam int MS_W    = 32;
    localparam int US_W    = 42;
    localparam int CNT_W   = 32;
    localparam int CMD_W   = 3;
    localparam int ACT_W   = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [MS_W-1:0] RELEASE_DEFAULT_MS = 32'd1000;
    localparam logic [US_W-1:0] US_PER_MS          = 42'd1000;
    localparam logic [US_W-1:0] RELEASE_DEFAULT_US = 42'd1000000;

    localparam logic [CMD_W-1:0] CMD_DISCOVER = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FRAME    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PRESET   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUIET    = 3'd4;

    localparam logic [ACT_W-1:0] ACT_IGNORE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_KNOWN   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ADOPTED = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REPLY   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ROLE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_ROLE = 8'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PEER_W-1:0] peer_addr;
        logic [ROLE_W-1:0] sender_role;
        logic [TIME_W-1:0] now_us;
        logic [MS_W-1:0]   window_ms;
    } in_item_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic              peer_present;
        logic              quiet;
        logic [CNT_W-1:0]  rejected_total;
        logic [CNT_W-1:0]  adoptions;
        logic [PEER_W-1:0] current_peer;
    } out_item_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PEER_W-1:0] peer_addr;
        logic [ROLE_W-1:0] sender_role;
        logic [TIME_W-1:0] now_us;
        logic [US_W-1:0]   window_us;
    } stage_t;

    typedef struct packed {
        logic [ROLE_W-1:0] node_role;
        logic [ROLE_W-1:0] unknown_role;
        logic [US_W-1:0]   release_us;
    } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/core/lpbt_cfg.sv -----
`default_nettype none
module lpbt_cfg
    import lpbt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t            cfg_reg;
    cfg_t            cfg_next;
    logic [MS_W-1:0] rel_ms;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // zero release time falls back to the default
    assign rel_ms = (cfg_data == '0) ? RELEASE_DEFAULT_MS : cfg_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NODE_ROLE:    cfg_next.node_role    = cfg_data[ROLE_W-1:0];
                CFG_RELEASE_MS:   cfg_next.release_us   = US_W'(rel_ms) * US_PER_MS;
                CFG_UNKNOWN_ROLE: cfg_next.unknown_role = cfg_data[ROLE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_role    <= '0;
            cfg_reg.unknown_role <= '0;
            cfg_reg.release_us   <= RELEASE_DEFAULT_US;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/lpbt_core.sv -----
`default_nettype none
module lpbt_core
    import lpbt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   advance,
    input  wire stage_t stage,
    input  wire cfg_t   cfg,
    output out_item_t   res
);

    logic [PEER_W-1:0] addr_reg, addr_next;
    logic              valid_reg, valid_next;
    logic              heard_reg, heard_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic [CNT_W-1:0]  rej_reg, rej_next;
    logic [CNT_W-1:0]  adopt_reg, adopt_next;

    logic [PEER_W-1:0] addr;
    logic [TIME_W-1:0] diff;
    logic              backwards;
    logic              match;
    logic              role_bad;
    logic              silent_rel;
    logic              silent_win;
    logic [ACT_W-1:0]  action;
    logic              quiet;

    assign addr      = stage.peer_addr & ADDR_MASK;
    assign match     = valid_reg && (addr_reg == addr);
    assign role_bad  = (stage.sender_role == cfg.unknown_role) ||
                       (stage.sender_role == cfg.node_role);
    assign diff      = stage.now_us - last_reg;
    assign backwards = stage.now_us < last_reg;
    assign silent_rel = !valid_reg || !heard_reg ||
                        (!backwards && (diff >= TIME_W'(cfg.release_us)));
    assign silent_win = !valid_reg || !heard_reg ||
                        (!backwards && (diff >= TIME_W'(stage.window_us)));

    always_comb
    begin
        addr_next  = addr_reg;
        valid_next = valid_reg;
        heard_next = heard_reg;
        last_next  = last_reg;
        rej_next   = rej_reg;
        adopt_next = adopt_reg;
        action     = ACT_IGNORE;
        quiet      = silent_win;
        case (stage.command)
            CMD_DISCOVER:
            begin
                if (role_bad)
                begin
                    rej_next = rej_reg + 1'b1;
                end
                else if (match)
                begin
                    heard_next = 1'b1;
                    last_next  = stage.now_us;
                    action     = ACT_REPLY;
                    quiet      = (stage.window_us == '0);
                end
                else if (silent_rel)
                begin
                    addr_next  = addr;
                    valid_next = 1'b1;
                    heard_next = 1'b1;
                    last_next  = stage.now_us;
                    adopt_next = adopt_reg + 1'b1;
                    action     = ACT_ADOPTED;
                    quiet      = (stage.window_us == '0);
                end
                else
                begin
                    rej_next = rej_reg + 1'b1;
                end
            end
            CMD_FRAME:
            begin
                if (match)
                begin
                    heard_next = 1'b1;
                    last_next  = stage.now_us;
                    action     = ACT_KNOWN;
                    quiet      = (stage.window_us == '0);
                end
                else
                begin
                    rej_next = rej_reg + 1'b1;
                end
            end
            CMD_PRESET:
            begin
                addr_next  = addr;
                valid_next = 1'b1;
                heard_next = 1'b0;
                last_next  = '0;
                quiet      = 1'b1;
            end
            CMD_RELEASE:
            begin
                addr_next  = '0;
                valid_next = 1'b0;
                heard_next = 1'b0;
                last_next  = '0;
                quiet      = 1'b1;
            end
            default:
            begin
                quiet = silent_win;
            end
        endcase
    end

    assign res.action         = action;
    assign res.peer_present   = valid_next;
    assign res.quiet          = quiet;
    assign res.rejected_total = rej_next;
    assign res.adoptions      = adopt_next;
    assign res.current_peer   = valid_next ? addr_next : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg  <= '0;
            valid_reg <= 1'b0;
            heard_reg <= 1'b0;
            last_reg  <= '0;
            rej_reg   <= '0;
            adopt_reg <= '0;
        end
        else if (advance)
        begin
            addr_reg  <= addr_next;
            valid_reg <= valid_next;
            heard_reg <= heard_next;
            last_reg  <= last_next;
            rej_reg   <= rej_next;
            adopt_reg <= adopt_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/link_peer_binding_tracker.sv -----
// Path: an accepted request is held in the stage register, and its result is
// registered in the result register when that register is empty or drained.
// Throughput: one request per cycle unless result_stall holds it; set by the
// input register and single pass of compare, 64-bit subtract, counter update.
// Reset: asynchronous, active low; clears both valid flags, the partner state,
// the counters and the registers to their defaults. No clearing pass.
`default_nettype none
module link_peer_binding_tracker
    import lpbt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire in_item_t              item,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output out_item_t                  result,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    stage_t    stage_reg;
    logic      stage_valid_reg;
    out_item_t res;
    out_item_t result_reg;
    logic      result_valid_reg;
    logic      advance;
    logic      take;

    lpbt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lpbt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .stage   (stage_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // advance when the result register is empty or being drained
    assign advance    = stage_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = stage_valid_reg && !advance;
    assign take       = item_valid && !item_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;

            if (advance)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg.command     <= item.command;
            stage_reg.peer_addr   <= item.peer_addr;
            stage_reg.sender_role <= item.sender_role;
            stage_reg.now_us      <= item.now_us;
            stage_reg.window_us   <= US_W'(item.window_ms) * US_PER_MS;
        end
        if (advance)
            result_reg <= res;
    end

endmodule
`default_nettype wire

// ----- rtl/core/lpbt_checker.sv -----
`default_nettype none
module lpbt_checker
    import lpbt_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  item_valid,
    input wire logic                  item_stall,
    input wire in_item_t              item,
    input wire logic                  result_valid,
    input wire logic                  result_stall,
    input wire out_item_t             result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_request_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("stalled request changed");

    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.peer_present |-> result.current_peer == '0)
        else $error("address shown with no partner bound");

    a_absent_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.peer_present |-> result.quiet)
        else $error("absent partner not quiet");

    a_action_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action != ACT_IGNORE) |-> result.peer_present)
        else $error("partner action with no partner bound");

endmodule

bind link_peer_binding_tracker lpbt_checker u_lpbt_checker (.*);
`default_nettype wire

// ----- sim/link_peer_binding_tracker_test.sv -----
`timescale 1ns / 100ps

module link_peer_binding_tracker_test;
    import lpbt_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 3;
    localparam logic [TIME_W-1:0] MS_TO_US = 64'd1000;
    localparam logic [TIME_W-1:0] LONGEST_US = 64'd4294967295 * 64'd1000;
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_QUIET + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = '1;
    localparam logic [PEER_W-1:0] ADDR_A = 48'h0200_5E10_00A1;
    localparam logic [PEER_W-1:0] ADDR_B = 48'h0A1B_2C3D_4E5F;
    localparam logic [PEER_W-1:0] ADDR_C = 48'hF0E1_D2C3_B4A5;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    in_item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    out_item_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // partner tracking state as the block should hold it
    logic [PEER_W-1:0] bound_addr = '0;
    logic bound_valid = 1'b0;
    logic bound_heard = 1'b0;
    logic [TIME_W-1:0] heard_at = '0;
    logic [CNT_W-1:0] role_rejects = '0;
    logic [CNT_W-1:0] busy_rejects = '0;
    logic [CNT_W-1:0] frame_rejects = '0;
    logic [CNT_W-1:0] adoption_total = '0;
    logic [ROLE_W-1:0] node_role_setting = '0;
    logic [ROLE_W-1:0] unknown_role_setting = '0;
    logic [MS_W-1:0] release_ms_setting = RELEASE_DEFAULT_MS;

    out_item_t awaited_status[$];
    int status_errors = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int idle_run = 0;
    logic [TIME_W-1:0] link_time_us = '0;
    logic [PEER_W-1:0] peer_pool[4];

    link_peer_binding_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic partner_silent(input logic [TIME_W-1:0] now,
                                            input logic [MS_W-1:0] ms);
        if (!bound_valid || !bound_heard)
            return 1'b1;
        // clock ran backwards: treat as recently heard
        if (now < heard_at)
            return 1'b0;
        return (now - heard_at) >= ({32'd0, ms} * MS_TO_US);
    endfunction

    function automatic out_item_t track_partner(input in_item_t ev);
        out_item_t st;
        logic [PEER_W-1:0] addr;
        addr = ev.peer_addr & ADDR_MASK;
        st.action = ACT_IGNORE;
        case (ev.command)
            CMD_DISCOVER:
            begin
                if (ev.sender_role == unknown_role_setting || ev.sender_role == node_role_setting)
                begin
                    role_rejects++;
                end
                else if (bound_valid && bound_addr == addr)
                begin
                    bound_heard = 1'b1;
                    heard_at = ev.now_us;
                    st.action = ACT_REPLY;
                end
                else if (!bound_valid || partner_silent(ev.now_us, release_ms_setting))
                begin
                    bound_addr = addr;
                    bound_valid = 1'b1;
                    bound_heard = 1'b1;
                    heard_at = ev.now_us;
                    adoption_total++;
                    st.action = ACT_ADOPTED;
                end
                else
                begin
                    busy_rejects++;
                end
            end
            CMD_FRAME:
            begin
                if (bound_valid && bound_addr == addr)
                begin
                    bound_heard = 1'b1;
                    heard_at = ev.now_us;
                    st.action = ACT_KNOWN;
                end
                else
                begin
                    frame_rejects++;
                end
            end
            CMD_PRESET:
            begin
                bound_addr = addr;
                bound_valid = 1'b1;
                bound_heard = 1'b0;
                heard_at = '0;
            end
            CMD_RELEASE:
            begin
                bound_addr = '0;
                bound_valid = 1'b0;
                bound_heard = 1'b0;
                heard_at = '0;
            end
            default: ;
        endcase
        st.peer_present = bound_valid;
        st.quiet = partner_silent(ev.now_us, ev.window_ms);
        st.rejected_total = role_rejects + busy_rejects + frame_rejects;
        st.adoptions = adoption_total;
        st.current_peer = bound_valid ? bound_addr : '0;
        return st;
    endfunction

    function automatic string status_text(input out_item_t s);
        return $sformatf("action=%0d present=%0b quiet=%0b rejected=%0d adoptions=%0d peer=%h",
                         s.action, s.peer_present, s.quiet, s.rejected_total, s.adoptions,
                         s.current_peer);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly plausible traffic around a small set of peers, some of it garbage
    function automatic in_item_t next_link_event();
        in_item_t ev;
        logic [TIME_W-1:0] span;
        logic [ROLE_W-1:0] role;
        int pick;
        span = {32'd0, release_ms_setting} * MS_TO_US;
        pick = $urandom_range(99);
        if (pick >= 95)
        begin
            ev.command = CMD_W'($urandom);
            ev.peer_addr = PEER_W'(rand64());
            ev.sender_role = ROLE_W'($urandom);
            ev.now_us = rand64();
            ev.window_ms = $urandom;
            return ev;
        end
        if (pick < 40)
            ev.command = CMD_DISCOVER;
        else if (pick < 70)
            ev.command = CMD_FRAME;
        else if (pick < 77)
            ev.command = CMD_PRESET;
        else if (pick < 82)
            ev.command = CMD_RELEASE;
        else if (pick < 92)
            ev.command = CMD_QUIET;
        else
            ev.command = CMD_W'($urandom_range(CMD_SPARE_LO, {CMD_W{1'b1}}));
        if ($urandom_range(99) < 80)
            ev.peer_addr = peer_pool[$urandom_range(3)];
        else
            ev.peer_addr = PEER_W'(rand64());
        if ($urandom_range(99) < 85)
        begin
            do
                role = ROLE_W'($urandom);
            while (role == node_role_setting || role == unknown_role_setting);
        end
        else
        begin
            role = $urandom_range(1) ? node_role_setting : unknown_role_setting;
        end
        ev.sender_role = role;
        if ($urandom_range(19) == 0)
        begin
            ev.now_us = link_time_us - (span * $urandom_range(1, 100)) / 100;
        end
        else
        begin
            link_time_us = link_time_us + (span * $urandom_range(0, 150)) / 100;
            ev.now_us = link_time_us;
        end
        case ($urandom_range(4))
            0: ev.window_ms = '0;
            1: ev.window_ms = release_ms_setting >> 1;
            2: ev.window_ms = release_ms_setting;
            3: ev.window_ms = release_ms_setting << 1;
            default: ev.window_ms = $urandom;
        endcase
        return ev;
    endfunction

    task automatic offer_event(input in_item_t ev);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= ev;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        awaited_status.push_back(track_partner(ev));
    endtask

    task automatic offer_fields(input logic [CMD_W-1:0] cmd, input logic [PEER_W-1:0] addr,
                                input logic [ROLE_W-1:0] role,
                                input logic [TIME_W-1:0] now,
                                input logic [MS_W-1:0] win);
        in_item_t ev;
        ev.command = cmd;
        ev.peer_addr = addr;
        ev.sender_role = role;
        ev.now_us = now;
        ev.window_ms = win;
        offer_event(ev);
    endtask

    // drop valid and wait until every request has reported back
    task automatic finish_burst();
        item_valid <= 1'b0;
        while (awaited_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NODE_ROLE: node_role_setting = data[ROLE_W-1:0];
            CFG_RELEASE_MS: release_ms_setting = (data != '0) ? data : RELEASE_DEFAULT_MS;
            CFG_UNKNOWN_ROLE: unknown_role_setting = data[ROLE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic test_directed_binding();
        write_register(CFG_NODE_ROLE, 32'h5A);
        write_register(CFG_UNKNOWN_ROLE, 32'hFF);
        write_register(CFG_RELEASE_MS, 32'd1);
        offer_fields(CMD_QUIET, '0, 8'h01, 64'd0, 32'd0);
        offer_fields(CMD_FRAME, ADDR_A, 8'h01, 64'd10, 32'd1);
        offer_fields(CMD_DISCOVER, ADDR_A, 8'hFF, 64'd20, 32'd1);
        offer_fields(CMD_DISCOVER, ADDR_A, 8'h5A, 64'd30, 32'd1);
        offer_fields(CMD_DISCOVER, ADDR_A, 8'h01, 64'd100, 32'd1);
        offer_fields(CMD_DISCOVER, ADDR_A, 8'h02, 64'd200, 32'd1);
        offer_fields(CMD_FRAME, ADDR_A, 8'h00, 64'd300, 32'd0);
        offer_fields(CMD_DISCOVER, ADDR_B, 8'h03, 64'd500, 32'd1);
        // silent for exactly the release time
        offer_fields(CMD_DISCOVER, ADDR_B, 8'h03, 64'd1300, 32'd1);
        // time behind the last heard request: partner counts as alive
        offer_fields(CMD_DISCOVER, ADDR_C, 8'h04, 64'd500, 32'd0);
        offer_fields(CMD_QUIET, ADDR_C, 8'h00, 64'd1300, 32'd0);
        offer_fields(CMD_PRESET, '1, 8'h00, 64'd1400, 32'd1);
        offer_fields(CMD_FRAME, '1, 8'h00, '1, 32'd1);
        offer_fields(CMD_QUIET, '1, 8'hFF, '1, '1);
        // a preset partner is never heard, so a stranger takes over
        offer_fields(CMD_PRESET, ADDR_A, 8'h00, 64'd0, 32'd0);
        offer_fields(CMD_DISCOVER, ADDR_B, 8'h01, 64'd0, 32'd0);
        offer_fields(CMD_RELEASE, ADDR_B, 8'h01, 64'd50, '1);
        for (int c = CMD_SPARE_LO; c < (1 << CMD_W); c++)
            offer_fields(CMD_W'(c), ADDR_C, 8'h7E, 64'd60, 32'd5);
        offer_fields(CMD_DISCOVER, '0, 8'h00, 64'd0, '1);
        offer_fields(CMD_QUIET, '0, 8'h00, 64'd0, '1);
        offer_fields(CMD_FRAME, ADDR_C, 8'h80, '1, '1);
        finish_burst();
    endtask

    task automatic test_register_corners();
        write_register(CFG_RELEASE_MS, 32'd0);
        write_register(CFG_SPARE, 32'hFFFF_FFFF);
        offer_fields(CMD_RELEASE, '0, 8'h00, 64'd0, 32'd0);
        offer_fields(CMD_DISCOVER, ADDR_A, 8'h01, 64'd0, 32'd0);
        offer_fields(CMD_DISCOVER, ADDR_B, 8'h01, 64'd999_999, 32'd1000);
        offer_fields(CMD_DISCOVER, ADDR_B, 8'h01, 64'd1_000_000, 32'd1000);
        finish_burst();
        write_register(CFG_RELEASE_MS, 32'hFFFF_FFFF);
        offer_fields(CMD_DISCOVER, ADDR_C, 8'h01, 64'd1_000_000 + LONGEST_US - 1, '1);
        offer_fields(CMD_DISCOVER, ADDR_C, 8'h01, 64'd1_000_000 + LONGEST_US, '1);
        finish_burst();
        write_register(CFG_NODE_ROLE, 32'h0);
        write_register(CFG_UNKNOWN_ROLE, 32'h0);
        offer_fields(CMD_DISCOVER, ADDR_A, 8'h00, 64'd5, 32'd0);
        offer_fields(CMD_DISCOVER, ADDR_C, 8'hFF, 64'd6, 32'd0);
        finish_burst();
        write_register(CFG_NODE_ROLE, 32'hFFFF_FFFF);
        write_register(CFG_UNKNOWN_ROLE, 32'h0000_00FF);
        offer_fields(CMD_DISCOVER, ADDR_A, 8'hFF, 64'd7, 32'd0);
        offer_fields(CMD_DISCOVER, ADDR_C, 8'h00, 64'd8, 32'd0);
        finish_burst();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++)
        begin
            finish_burst();
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    write_register(CFG_NODE_ROLE, 32'h00);
                    write_register(CFG_UNKNOWN_ROLE, 32'h00);
                    write_register(CFG_RELEASE_MS, 32'd0);
                end
                1:
                begin
                    send_idle_pct = 75;
                    stall_pct = 0;
                    write_register(CFG_NODE_ROLE, 32'hFF);
                    write_register(CFG_UNKNOWN_ROLE, 32'h00);
                    write_register(CFG_RELEASE_MS, 32'd1);
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 75;
                    write_register(CFG_NODE_ROLE, $urandom);
                    write_register(CFG_UNKNOWN_ROLE, $urandom);
                    write_register(CFG_RELEASE_MS, $urandom_range(1, 50));
                end
                default:
                begin
                    send_idle_pct = 14;
                    stall_pct = 14;
                    write_register(CFG_NODE_ROLE, 32'h01);
                    write_register(CFG_UNKNOWN_ROLE, 32'hFE);
                    write_register(CFG_RELEASE_MS, 32'hFFFF_FFFF);
                end
            endcase
            foreach (peer_pool[i])
                peer_pool[i] = PEER_W'(rand64());
            repeat (260) offer_event(next_link_event());
        end
        finish_burst();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        // long hold on the result side while requests keep coming
        hold_requests++;
        repeat (40) offer_event(next_link_event());
        finish_burst();
        send_idle_pct = 30;
        stall_pct = 30;
        repeat (10) offer_event(next_link_event());
        finish_burst();
        repeat (10) offer_event(next_link_event());
        finish_burst();
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else if (hold_requests != holds_served)
        begin
            result_stall <= 1'b1;
            hold_left = HOLD_CYCLES;
            holds_served++;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid === 1'b1 && !result_stall)
        begin
            if (awaited_status.size() == 0)
            begin
                if (status_errors < 10)
                    $display("unexpected result: %s", status_text(result));
                status_errors++;
            end
            else
            begin
                want = awaited_status.pop_front();
                if (result.action !== want.action || result.peer_present !== want.peer_present
                    || result.quiet !== want.quiet
                    || result.rejected_total !== want.rejected_total
                    || result.adoptions !== want.adoptions
                    || result.current_peer !== want.current_peer)
                begin
                    if (status_errors < 10)
                    begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", status_text(want));
                        $display("  actual   %s", status_text(result));
                    end
                    status_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("FAIL link_peer_binding_tracker");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_binding();
        test_register_corners();
        test_random_traffic();
        test_backpressure();
        finish_burst();
        repeat (10) @(posedge clk);
        status_errors += awaited_status.size();
        if (status_errors == 0)
            $display("PASS link_peer_binding_tracker");
        else
            $display("FAIL link_peer_binding_tracker");
        $finish;
    end

endmodule
